### sv/event_interval_statistics_defines.svh
// Assertion macros used by the checker of this block.
`ifndef EVENT_INTERVAL_STATISTICS_DEFINES_SVH
`define EVENT_INTERVAL_STATISTICS_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define EVIS_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("evis check failed");

// Next-cycle implication, also checked through reset.
`define EVIS_AST_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("evis check failed");

`endif

### sv/evis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package evis_pkg;
    localparam int SAMPLE_DEPTH = 8192;
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W        = 14;
    localparam int SUM_W        = 32 + IDX_W;
    localparam int NUM_W        = SUM_W + 5;
    localparam int DIV_W        = CNT_W + 2;
    localparam int MEAN_W       = 36;
    localparam int RANK_V_W     = 20;
    localparam int RANK_MUL     = 1342178;
    localparam int RANK_SHIFT   = 27;
    localparam int PROD_W       = RANK_V_W + 21;

    typedef struct packed {
        logic        is_close;
        logic [31:0] time_ms;
    } t_cmd;

    typedef struct packed {
        logic [31:0]       total_events;
        logic [31:0]       max_interval;
        logic [31:0]       p95_interval;
        logic [31:0]       min_interval;
        logic [MEAN_W-1:0] mean_tenths;
        logic              stats_valid;
        logic [CNT_W-1:0]  sample_count;
        logic [31:0]       window_events;
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RANK = 5'b00010,
        ST_SEL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;
endpackage
`default_nettype wire

### sv/evis_front.sv
`timescale 1ns / 1ps
`default_nettype none
module evis_front import evis_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [31:0] i_s_tdata,
    input  wire        i_s_tuser,
    output logic       o_valid,
    input  wire        i_ready,
    output t_cmd       o_cmd
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rp;
    logic       r_wp;
    logic       push;
    logic       pop;

    assign o_s_tready = (r_cnt != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_cmd      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].is_close <= i_s_tuser;
            r_q[r_wp].time_ms  <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### sv/evis_back.sv
`timescale 1ns / 1ps
`default_nettype none
module evis_back import evis_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    input  wire  i_res_ready,
    output t_res o_res
);
    logic [31:0]       r_mem [SAMPLE_DEPTH];
    logic [31:0]       r_rd_data;
    t_state            r_state;
    logic              r_prev_valid;
    logic [31:0]       r_prev_time;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_win;
    logic [31:0]       r_tot;
    logic [SUM_W-1:0]  r_sum;
    logic [31:0]       r_min;
    logic [31:0]       r_max;
    logic [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_v;
    logic [4:0]        r_bit;
    logic [31:0]       r_cand;
    logic [NUM_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_rem;
    logic [MEAN_W-1:0] r_q;
    logic [5:0]        r_dcnt;
    logic              r_ov;
    t_res              r_res;

    logic              take;
    logic              ev;
    logic              store;
    logic [31:0]       delta;
    logic [RANK_V_W-1:0] rank_v;
    logic [31:0]       hi_mask;
    logic              hit;
    logic [DIV_W-1:0]  rem_sh;
    logic [DIV_W-1:0]  divisor;
    logic              out_free;

    assign o_ready     = (r_state == ST_IDLE);
    assign take        = i_valid && o_ready;
    assign ev          = take && !i_cmd.is_close;
    assign store       = ev && r_prev_valid && (r_count < CNT_W'(SAMPLE_DEPTH));
    assign delta       = i_cmd.time_ms - r_prev_time;
    assign rank_v      = RANK_V_W'(r_count) * RANK_V_W'(95) + RANK_V_W'(99);
    assign hi_mask     = ~(32'hFFFF_FFFF >> (5'd31 - r_bit));
    assign hit         = (((r_rd_data ^ r_cand) & hi_mask) == 32'd0) && !r_rd_data[r_bit];
    assign rem_sh      = {r_rem[DIV_W-2:0], r_num[NUM_W-1]};
    assign divisor     = {1'b0, r_count, 1'b0};
    assign out_free    = !r_ov || i_res_ready;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (store) r_mem[r_count[IDX_W-1:0]] <= delta;
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_prod <= PROD_W'(rank_v) * PROD_W'(RANK_MUL);
            r_num  <= NUM_W'({r_sum, 4'd0}) + NUM_W'({r_sum, 2'd0}) + NUM_W'(r_count);
            r_rem  <= '0;
            r_q    <= '0;
            r_dcnt <= 6'(NUM_W - 1);
            r_cand <= '0;
            r_hits <= '0;
            r_idx  <= '0;
            r_bit  <= 5'd31;
        end
        if (r_state == ST_RANK) r_k <= r_prod[RANK_SHIFT +: CNT_W];
        if (r_state == ST_SEL) begin
            if (r_idx < r_count) r_idx <= r_idx + 1'b1;
            if (r_rd_v) begin
                if (hit) r_hits <= r_hits + 1'b1;
            end else if (r_idx == r_count) begin
                // pass over: settle this bit of the candidate
                if (r_k > r_hits) begin
                    r_cand[r_bit] <= 1'b1;
                    r_k           <= r_k - r_hits;
                end
                r_hits <= '0;
                r_idx  <= '0;
                r_bit  <= r_bit - 1'b1;
            end
        end
        if (r_state == ST_DIV) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_dcnt <= r_dcnt - 1'b1;
            if (rem_sh >= divisor) begin
                r_rem <= rem_sh - divisor;
                r_q   <= {r_q[MEAN_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[MEAN_W-2:0], 1'b0};
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_res.window_events <= r_win;
            r_res.sample_count  <= r_count;
            r_res.stats_valid   <= (r_count != '0);
            r_res.mean_tenths   <= (r_count != '0) ? r_q : '0;
            r_res.min_interval  <= (r_count != '0) ? r_min : 32'd0;
            r_res.p95_interval  <= (r_count != '0) ? r_cand : 32'd0;
            r_res.max_interval  <= (r_count != '0) ? r_max : 32'd0;
            r_res.total_events  <= r_tot;
        end
        if (store) begin
            r_min <= (r_count == '0 || delta < r_min) ? delta : r_min;
            r_max <= (r_count == '0 || delta > r_max) ? delta : r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev_valid <= 1'b0;
            r_prev_time  <= '0;
            r_count      <= '0;
            r_win        <= '0;
            r_tot        <= '0;
            r_sum        <= '0;
            r_rd_v       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_rd_v <= (r_state == ST_SEL) && (r_idx < r_count);
            if (r_state == ST_DONE && out_free) r_ov <= 1'b1;
            else if (i_res_ready) r_ov <= 1'b0;
            if (ev) begin
                if (r_tot != 32'hFFFF_FFFF) r_tot <= r_tot + 1'b1;
                if (r_win != 32'hFFFF_FFFF) r_win <= r_win + 1'b1;
                r_prev_time  <= i_cmd.time_ms;
                r_prev_valid <= 1'b1;
            end
            if (store) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(delta);
            end
            case (r_state)
                ST_IDLE: begin
                    if (take && i_cmd.is_close) begin
                        r_state <= (r_count == '0) ? ST_DONE : ST_RANK;
                    end
                end
                ST_RANK: r_state <= ST_SEL;
                ST_SEL: begin
                    if (!r_rd_v && r_idx == r_count && r_bit == 5'd0) r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == 6'd0) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_count      <= '0;
                        r_win        <= '0;
                        r_sum        <= '0;
                        r_prev_valid <= 1'b0;
                        r_prev_time  <= '0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/event_interval_statistics.sv
// Frame event: registered in the request queue, then taken by the back end;
//   back-to-back events sustain one per cycle while no close request is in progress.
// Close request: for n > 0 stored samples the result is set by 32 bit-select passes over
//   the sample memory and a 50-step divider; when empty both are skipped.
// Reset (synchronous, active low) clears counters, queue and output valid flag;
//   the sample memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module event_interval_statistics import evis_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [31:0]  i_s_tdata,   // time_ms
    input  wire          i_s_tuser,   // action
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // window_events, sample_count, mean_tenths, min_interval, p95_interval,
    // max_interval, total_events, zero fill
    output logic [215:0] o_m_tdata,
    output logic         o_m_tuser    // stats_valid
);
    logic valid;
    logic ready;
    t_cmd cmd;
    t_res res;

    evis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_valid    (valid),
        .i_ready    (ready),
        .o_cmd      (cmd)
    );

    evis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (valid),
        .o_ready     (ready),
        .i_cmd       (cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {6'd0, res.total_events, res.max_interval, res.p95_interval,
                        res.min_interval, res.mean_tenths, res.sample_count,
                        res.window_events};
    assign o_m_tuser = res.stats_valid;
endmodule
`default_nettype wire

### sv/evis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "event_interval_statistics_defines.svh"
module evis_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [215:0] o_m_tdata,
    input wire         o_m_tuser
);
    logic stalled;
    logic ordered;

    assign stalled = o_m_tvalid && !i_m_tready && i_rst_n;
    assign ordered = (o_m_tdata[45:32] != '0)
                     && (o_m_tdata[113:82] <= o_m_tdata[145:114])
                     && (o_m_tdata[145:114] <= o_m_tdata[177:146]);

    `EVIS_AST_NXT(a_rst_clears_out, i_clk, !i_rst_n, !o_m_tvalid)
    `EVIS_AST_NXT(a_hold_stalled, i_clk, stalled, $stable(o_m_tdata))
    `EVIS_AST_IMP(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[177:32] == '0)
    `EVIS_AST_IMP(a_order, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, ordered)
endmodule

bind event_interval_statistics evis_checker u_evis_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
